FILE: rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// shared types, constants and codes of the speech segment detector
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int WINDOW_SAMPLES = 512;
  localparam int TIME_BITS      = 48;

  localparam int TS_W     = 48;
  localparam int PROB_W   = 16;
  localparam int PAD_W    = 12;
  localparam int MS_W     = 16;
  localparam int MS_SHIFT = 4;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_ADDR_W-1:0] CFG_SPEECH_THR  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SILENCE_THR = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PAD_MS      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_SIL_MS  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_SPE_MS  = 3'd4;

  localparam logic [PROB_W-1:0] AUTO_DROP  = 16'd9830;
  localparam logic [PROB_W-1:0] AUTO_FLOOR = 16'd655;

  typedef logic [TIME_BITS-1:0] time_t;

  localparam time_t WIN_T = time_t'(WINDOW_SAMPLES);

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_START = 3'd1,
    KIND_END   = 3'd2,
    KIND_FINAL = 3'd3,
    KIND_DISC  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [PROB_W-1:0] speech_thr;
    logic [PROB_W-1:0] lower_thr;
    logic [PAD_W-1:0]  pad_ms;
    logic [MS_W-1:0]   min_silence_ms;
    logic [MS_W-1:0]   min_speech_ms;
  } cfg_t;

  typedef struct packed {
    logic              func;
    logic [PROB_W-1:0] probability;
    logic [TS_W-1:0]   window_start;
  } item_t;

  typedef struct packed {
    kind_t             kind;
    logic [TS_W-1:0]   event_sample;
    logic [TS_W-1:0]   segment_start;
    logic [TS_W-1:0]   segment_end;
    logic [PROB_W-1:0] event_probability;
  } res_t;

endpackage

FILE: rtl/streaming_speech_segment_detector.sv
// ----------------------------------------------------------------------------
// streaming_speech_segment_detector
// speech start and end events from per-window speech probabilities
// ----------------------------------------------------------------------------
// Takes one word per clock while the output is not stalled and returns
// exactly one result word for each, held first in the input register, then
// in the result register, with all detector
// arithmetic (compares, adds, the hysteresis update) in the single stage
// between them. The rate is set by that one stage and the stall chain from
// out_tready back to in_tready. Configuration writes take effect at once
// and are meant to happen only while no word is in flight.
module streaming_speech_segment_detector (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [63:0]                    in_tdata,   // probability, window_start
  input  logic                           in_tuser,   // func
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [159:0]                   out_tdata,  // event_sample, segment_start,
                                                     // segment_end, event_probability
  output logic [2:0]                     out_tuser,  // kind
  input  logic                           cfg_we,
  input  logic [ssd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ssd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ssd_pkg::*;

  cfg_t  cfg;
  item_t s1_item_r;
  logic  s1_valid_r;
  res_t  res, out_res_r;
  logic  out_valid_r;
  logic  adv1, adv2, step;

  ssd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ssd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign adv2      = !out_valid_r || out_tready;
  assign adv1      = !s1_valid_r || adv2;
  assign step      = s1_valid_r && adv2;
  assign in_tready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) s1_valid_r <= in_tvalid;
      if (adv2) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_tvalid) begin
      s1_item_r.func         <= in_tuser;
      s1_item_r.probability  <= in_tdata[15:0];
      s1_item_r.window_start <= in_tdata[63:16];
    end
    if (step) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.event_probability, out_res_r.segment_end,
                       out_res_r.segment_start, out_res_r.event_sample};
  assign out_tuser  = out_res_r.kind;

endmodule

FILE: rtl/ssd_cfg.sv
// ----------------------------------------------------------------------------
// ssd_cfg
// configuration registers and the lower threshold selection
// ----------------------------------------------------------------------------
module ssd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ssd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ssd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ssd_pkg::cfg_t                  cfg
);
  import ssd_pkg::*;

  logic [PROB_W-1:0]     speech_thr_r;
  logic [CFG_DATA_W-1:0] silence_thr_r;
  logic [PAD_W-1:0]      pad_ms_r;
  logic [MS_W-1:0]       min_sil_ms_r;
  logic [MS_W-1:0]       min_spe_ms_r;
  logic [PROB_W-1:0]     auto_thr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speech_thr_r  <= 16'd32768;
      silence_thr_r <= '1;
      pad_ms_r      <= 12'd30;
      min_sil_ms_r  <= 16'd100;
      min_spe_ms_r  <= 16'd250;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SPEECH_THR:  speech_thr_r  <= cfg_wdata[PROB_W-1:0];
        CFG_SILENCE_THR: silence_thr_r <= cfg_wdata;
        CFG_PAD_MS:      pad_ms_r      <= cfg_wdata[PAD_W-1:0];
        CFG_MIN_SIL_MS:  min_sil_ms_r  <= cfg_wdata[MS_W-1:0];
        CFG_MIN_SPE_MS:  min_spe_ms_r  <= cfg_wdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // negative register selects threshold minus 0.15, floored at 0.01
  assign auto_thr = (speech_thr_r >= AUTO_DROP + AUTO_FLOOR) ?
                    speech_thr_r - AUTO_DROP : AUTO_FLOOR;

  always_comb begin
    cfg.speech_thr     = speech_thr_r;
    cfg.lower_thr      = silence_thr_r[CFG_DATA_W-1] ? auto_thr
                                                     : silence_thr_r[PROB_W-1:0];
    cfg.pad_ms         = pad_ms_r;
    cfg.min_silence_ms = min_sil_ms_r;
    cfg.min_speech_ms  = min_spe_ms_r;
  end

endmodule

FILE: rtl/ssd_core.sv
// ----------------------------------------------------------------------------
// ssd_core
// hysteresis detector state and the result of one word
// ----------------------------------------------------------------------------
module ssd_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  ssd_pkg::item_t item,
  input  ssd_pkg::cfg_t  cfg,
  output ssd_pkg::res_t  res
);
  import ssd_pkg::*;

  logic  in_speech_r, in_speech_nxt;
  time_t mark_r, mark_nxt;
  time_t oss_r, oss_nxt;
  time_t ens_r, ens_nxt;

  time_t              ws, pad, min_sil, min_sp;
  time_t              win_end, span, start_pad;
  time_t              mark_a, mark_b, sil_len, end_t, seg_end;
  logic [TIME_BITS:0] ext;
  logic               high, low, disc, fin_ok;

  always_comb begin
    ws      = time_t'(item.window_start);
    pad     = time_t'(cfg.pad_ms) << MS_SHIFT;
    min_sil = time_t'(cfg.min_silence_ms) << MS_SHIFT;
    min_sp  = time_t'(cfg.min_speech_ms) << MS_SHIFT;
    win_end = ws + WIN_T;
    high    = item.probability >= cfg.speech_thr;
    low     = item.probability < cfg.lower_thr;
    disc    = (ens_r != '0) && (ws != ens_r);
    span    = ens_r - oss_r;
    fin_ok  = in_speech_r && (ens_r > oss_r) && (span > min_sp);
    start_pad = (ws > pad) ? ws - pad : '0;
    // a strong window cancels pending silence
    mark_a  = high ? '0 : mark_r;
    mark_b  = (mark_a == '0) ? win_end : mark_a;
    sil_len = win_end - mark_b;
    ext     = {1'b0, mark_b} + {1'b0, pad};
    end_t   = (ext >= (TIME_BITS+1)'(WINDOW_SAMPLES)) ? ext[TIME_BITS-1:0] - WIN_T : '0;
    seg_end = (end_t > oss_r) ? end_t : oss_r;

    in_speech_nxt = in_speech_r;
    mark_nxt      = mark_r;
    oss_nxt       = oss_r;
    ens_nxt       = ens_r;
    res           = '0;
    res.kind      = KIND_NONE;

    if (item.func) begin
      if (fin_ok) begin
        res.kind              = KIND_FINAL;
        res.event_sample      = TS_W'(ens_r);
        res.segment_start     = TS_W'(oss_r);
        res.segment_end       = TS_W'(ens_r);
        res.event_probability = cfg.speech_thr;
      end
    end else if (disc) begin
      res.kind              = KIND_DISC;
      res.event_sample      = TS_W'(ens_r);
      res.event_probability = item.probability;
    end else begin
      ens_nxt  = win_end;
      mark_nxt = mark_a;
      if (high && !in_speech_r) begin
        in_speech_nxt         = 1'b1;
        oss_nxt               = start_pad;
        res.kind              = KIND_START;
        res.event_sample      = TS_W'(start_pad);
        res.event_probability = item.probability;
      end else if (low && in_speech_r) begin
        mark_nxt = mark_b;
        if (sil_len >= min_sil) begin
          res.kind              = KIND_END;
          res.event_sample      = TS_W'(end_t);
          res.segment_start     = TS_W'(oss_r);
          res.segment_end       = TS_W'(seg_end);
          res.event_probability = item.probability;
          in_speech_nxt         = 1'b0;
          mark_nxt              = '0;
          oss_nxt               = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_speech_r <= 1'b0;
      mark_r      <= '0;
      oss_r       <= '0;
      ens_r       <= '0;
    end else if (step) begin
      in_speech_r <= in_speech_nxt;
      mark_r      <= mark_nxt;
      oss_r       <= oss_nxt;
      ens_r       <= ens_nxt;
    end
  end

endmodule

FILE: rtl/ssd_checker.sv
// ----------------------------------------------------------------------------
// ssd_checker
// port-level checks on the result stream of the segment detector
// ----------------------------------------------------------------------------
module ssd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata,
  input logic [2:0]   out_tuser
);
  import ssd_pkg::*;

  logic [TS_W-1:0] ev, seg_s, seg_e;

  assign ev    = out_tdata[47:0];
  assign seg_s = out_tdata[95:48];
  assign seg_e = out_tdata[143:96];

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_NONE |-> out_tdata == '0)
    else $error("empty result carries data");

  a_seg_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_END || out_tuser == KIND_FINAL) |-> seg_e >= seg_s)
    else $error("segment end before segment start");

  a_final_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_FINAL |-> ev == seg_e && seg_e > seg_s)
    else $error("final segment inconsistent");

endmodule

bind streaming_speech_segment_detector ssd_checker u_ssd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: dv/streaming_speech_segment_detector_tb.sv
// ----------------------------------------------------------------------------
// streaming_speech_segment_detector_tb
// self-checking bench for the speech segment detector: probability words are
// streamed in, a local hysteresis model predicts one result per word and the
// monitor compares every result field with the oldest prediction, over a set
// of threshold, padding and silence settings and several idle/stall mixes
// ----------------------------------------------------------------------------
module streaming_speech_segment_detector_tb;
  import ssd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 4;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [63:0]           in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [159:0]          out_tdata;
  logic [2:0]            out_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  streaming_speech_segment_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // register mirror, reset values
  logic [15:0] c_speech_thr = 16'd32768;
  logic [16:0] c_sil_thr    = 17'h1FFFF;
  logic [11:0] c_pad_ms     = 12'd30;
  logic [15:0] c_min_sil_ms = 16'd100;
  logic [15:0] c_min_spe_ms = 16'd250;

  // detector state mirror
  logic  st_in_speech = 1'b0;
  time_t st_sil_mark  = '0;
  time_t st_seg_open  = '0;
  time_t st_next_ws   = '0;

  item_t window_words[$];
  res_t  predicted_events[$];
  time_t gen_next = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int n_words        = 0;
  int n_phases       = 0;
  int idle_cycles    = 0;
  int kind_seen[5]   = '{default: 0};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] silence_level();
    if (c_sil_thr[16]) begin
      if (c_speech_thr >= AUTO_DROP + AUTO_FLOOR) return c_speech_thr - AUTO_DROP;
      return AUTO_FLOOR;
    end
    return c_sil_thr[15:0];
  endfunction

  function automatic res_t detect_segment(input item_t w);
    res_t        r;
    logic [63:0] pad;
    logic [63:0] min_len;
    logic [63:0] end_s;
    time_t       win_end;
    time_t       stt;
    logic        high;
    r   = '0;
    pad = 64'(c_pad_ms) << 4;
    if (w.func) begin
      min_len = 64'(c_min_spe_ms) << 4;
      if (st_in_speech && st_next_ws > st_seg_open &&
          64'(st_next_ws) - 64'(st_seg_open) > min_len) begin
        r.kind              = KIND_FINAL;
        r.event_sample      = st_next_ws;
        r.segment_start     = st_seg_open;
        r.segment_end       = st_next_ws;
        r.event_probability = c_speech_thr;
      end
      return r;
    end
    if (st_next_ws != '0 && w.window_start != st_next_ws) begin
      r.kind              = KIND_DISC;
      r.event_sample      = st_next_ws;
      r.event_probability = w.probability;
      return r;
    end
    high    = w.probability >= c_speech_thr;
    win_end = w.window_start + WIN_T;
    if (high) st_sil_mark = '0;
    if (high && !st_in_speech) begin
      stt = (64'(w.window_start) > pad) ? w.window_start - time_t'(pad) : '0;
      st_in_speech        = 1'b1;
      st_seg_open         = stt;
      r.kind              = KIND_START;
      r.event_sample      = stt;
      r.event_probability = w.probability;
    end else if (w.probability < silence_level() && st_in_speech) begin
      min_len = 64'(c_min_sil_ms) << 4;
      if (st_sil_mark == '0) st_sil_mark = win_end;
      if (64'(time_t'(win_end - st_sil_mark)) >= min_len) begin
        end_s = '0;
        if (pad >= 64'(WINDOW_SAMPLES) || 64'(st_sil_mark) >= 64'(WINDOW_SAMPLES) - pad)
          end_s = 64'(time_t'(64'(st_sil_mark) + pad - 64'(WINDOW_SAMPLES)));
        r.kind              = KIND_END;
        r.event_sample      = time_t'(end_s);
        r.segment_start     = st_seg_open;
        r.segment_end       = (time_t'(end_s) > st_seg_open) ? time_t'(end_s) : st_seg_open;
        r.event_probability = w.probability;
        st_in_speech        = 1'b0;
        st_sil_mark         = '0;
        st_seg_open         = '0;
      end
    end
    st_next_ws = win_end;
    return r;
  endfunction

  // stimulus helpers
  task automatic queue_window(input time_t ws, input logic [15:0] prob);
    item_t w;
    w.func         = 1'b0;
    w.probability  = prob;
    w.window_start = ws;
    window_words.insert(window_words.size(), w);
    if (gen_next == '0 || ws == gen_next) gen_next = ws + WIN_T;
  endtask

  task automatic queue_finalize(input logic [15:0] prob);
    item_t w;
    w.func         = 1'b1;
    w.probability  = prob;
    w.window_start = time_t'({$urandom, $urandom});
    window_words.insert(window_words.size(), w);
  endtask

  function automatic time_t jump_target();
    time_t t;
    t = time_t'({$urandom, $urandom});
    if (t == gen_next) t = t ^ time_t'(1);
    return t;
  endfunction

  function automatic logic [15:0] middle_prob();
    logic [15:0] lw;
    lw = silence_level();
    if (lw < c_speech_thr) return 16'($urandom_range(lw, c_speech_thr - 16'd1));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] loud_prob();
    int r;
    r = $urandom_range(15);
    if (r == 0) return c_speech_thr;
    if (r == 1) return middle_prob();
    return 16'($urandom_range(c_speech_thr, 16'hFFFF));
  endfunction

  function automatic logic [15:0] quiet_prob();
    logic [15:0] lw;
    int          r;
    lw = silence_level();
    r  = $urandom_range(15);
    if (r == 0) return lw;
    if (r == 1) return middle_prob();
    if (lw == '0) return '0;
    if (r == 2) return lw - 16'd1;
    return 16'($urandom_range(lw - 16'd1, 0));
  endfunction

  function automatic int silence_run_max();
    int n;
    n = int'(c_min_sil_ms >> 5) + 3;
    return (n > 40) ? 40 : n;
  endfunction

  // mostly contiguous speech and silence runs, some finalize and jumps
  task automatic queue_random_traffic(input int n);
    int cnt;
    int r;
    int len;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(99);
      if (r < 6) begin
        queue_finalize(16'($urandom));
        cnt++;
      end else if (r < 11) begin
        queue_window(jump_target(), 16'($urandom));
        cnt++;
      end else if (r < 20) begin
        queue_window(gen_next, 16'($urandom));
        cnt++;
      end else if (r < 58) begin
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++) queue_window(gen_next, loud_prob());
        cnt += len;
      end else begin
        len = $urandom_range(1, silence_run_max());
        for (int k = 0; k < len; k++) queue_window(gen_next, quiet_prob());
        cnt += len;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SPEECH_THR:  c_speech_thr = val[15:0];
      CFG_SILENCE_THR: c_sil_thr    = val[16:0];
      CFG_PAD_MS:      c_pad_ms     = val[11:0];
      CFG_MIN_SIL_MS:  c_min_sil_ms = val[15:0];
      CFG_MIN_SPE_MS:  c_min_spe_ms = val[15:0];
      default: ;
    endcase
  endtask

  task automatic program_detector(input logic [15:0] thr, input logic [16:0] sil,
                                  input logic [11:0] pad, input logic [15:0] msil,
                                  input logic [15:0] mspe);
    write_reg(CFG_SPEECH_THR, 17'(thr));
    write_reg(CFG_SILENCE_THR, sil);
    write_reg(CFG_PAD_MS, 17'(pad));
    write_reg(CFG_MIN_SIL_MS, 17'(msil));
    write_reg(CFG_MIN_SPE_MS, 17'(mspe));
    // unused indexes must not disturb anything
    for (int a = int'(CFG_MIN_SPE_MS) + 1; a < (1 << CFG_ADDR_W); a++)
      write_reg(CFG_ADDR_W'(a), CFG_DATA_W'($urandom));
  endtask

  task automatic drain_detector();
    while (window_words.size() != 0 || in_tvalid || predicted_events.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int n, input int send_idle, input int recv_stall);
    send_idle_pct  = send_idle;
    recv_stall_pct = recv_stall;
    n_phases++;
    queue_random_traffic(n / 2);
    // sender holds until every result is back
    drain_detector();
    queue_random_traffic(n - n / 2);
    drain_detector();
  endtask

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // driver
  always @(posedge clk) begin
    item_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (window_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = window_words.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {w.window_start, w.probability};
        in_tuser  <= w.func;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    item_t w;
    res_t  want;
    res_t  got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        w.func         = in_tuser;
        w.probability  = in_tdata[15:0];
        w.window_start = in_tdata[63:16];
        predicted_events.insert(predicted_events.size(), detect_segment(w));
        n_words++;
      end
      if (out_tvalid && out_tready) begin
        got.kind              = kind_t'(out_tuser);
        got.event_sample      = out_tdata[47:0];
        got.segment_start     = out_tdata[95:48];
        got.segment_end       = out_tdata[143:96];
        got.event_probability = out_tdata[159:144];
        if (predicted_events.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none, actual kind %0d",
                   $time, out_tuser);
        end else begin
          want = predicted_events.pop_front();
          report_field("kind", 64'(want.kind), 64'(got.kind));
          report_field("event_sample", 64'(want.event_sample), 64'(got.event_sample));
          report_field("segment_start", 64'(want.segment_start), 64'(got.segment_start));
          report_field("segment_end", 64'(want.segment_end), 64'(got.segment_end));
          report_field("event_probability", 64'(want.event_probability),
                       64'(got.event_probability));
        end
        if (out_tuser <= 3'(KIND_DISC)) kind_seen[out_tuser]++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("** streaming_speech_segment_detector: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed run on reset settings, stream placed just below the time wrap
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    queue_finalize(16'hFFFF);
    queue_window(48'd0 - 48'd3052, 16'h0000);
    queue_window(gen_next, c_speech_thr);
    queue_window(gen_next, silence_level());
    queue_window(gen_next, 16'hFFFF);
    queue_window(gen_next, 16'd40000);
    // silence mark wraps to a small value, end sample saturates at zero
    queue_window(gen_next, 16'h0000);
    repeat (4) queue_window(gen_next, 16'h0000);
    queue_window(gen_next, 16'hFFFF);
    queue_finalize(16'h1234);
    repeat (6) queue_window(gen_next, 16'hFFFF);
    queue_finalize(16'h0000);
    queue_window(48'h5555_5555_5555, 16'hAAAA);
    queue_window(48'd0, 16'h0000);
    drain_detector();

    program_detector(16'd30000, 17'h1FFFF, 12'd4095, 16'd50, 16'd100);
    run_phase(115, 0, 0);
    program_detector(16'hFFFF, 17'h0FFFF, 12'd0, 16'd0, 16'd0);
    run_phase(115, 48, 0);
    program_detector(16'd0, 17'h00000, 12'd31, 16'hFFFF, 16'hFFFF);
    run_phase(50, 0, 48);
    program_detector(16'd10485, 17'h10000, 12'd32, 16'd32, 16'd32);
    run_phase(115, 15, 15);
    program_detector(16'd10484, 17'h1FFFF, 12'd30, 16'd100, 16'd250);
    run_phase(115, 0, 0);
    program_detector(16'd45000, 17'd20000, 12'd100, 16'd200, 16'd500);
    run_phase(115, 48, 0);
    program_detector(16'd20000, 17'd19999, 12'd1, 16'd16, 16'd1000);
    run_phase(115, 0, 48);
    program_detector(16'd50000, 17'h1FFFF, 12'd2000, 16'd1000, 16'd2000);
    run_phase(115, 15, 15);

    $display("run covered %0d words over a directed pass and %0d register settings",
             n_words, n_phases);
    $display("results seen: %0d none, %0d start, %0d end, %0d final, %0d discontinuity",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (errors == 0 && predicted_events.size() == 0) begin
      $display("** streaming_speech_segment_detector: PASSED **");
    end else begin
      $display("** streaming_speech_segment_detector: FAILED **");
    end
    $finish;
  end

endmodule
